@@ hdl/v4au_pkg.sv @@
// ----------------------------------------------------------------------------
// v4au_pkg
// Types, opcodes, constants and saturation helper for the four-lane vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package v4au_pkg;

   localparam int LANE_COUNT        = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int Q_W               = 32;
   localparam int PROD_W            = 66;
   localparam int SUM_W             = 68;
   localparam int ROOT_W            = 34;
   localparam int SQRT_STAGES       = SUM_W / 2;
   localparam int DIV_STAGES        = 32;
   localparam int DEN_W             = 34;

   localparam logic [Q_W-1:0] QMAX32 = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] QMIN32 = 32'h8000_0000;

   localparam logic signed [SUM_W-1:0] Q_MAX = 68'sd2147483647;
   localparam logic signed [SUM_W-1:0] Q_MIN = -(68'sd2147483648);

   typedef enum logic [3:0] {
      OP_VV_ADD = 4'd0,
      OP_VV_SUB = 4'd1,
      OP_VV_MUL = 4'd2,
      OP_VV_DIV = 4'd3,
      OP_VS_ADD = 4'd4,
      OP_VS_SUB = 4'd5,
      OP_SV_SUB = 4'd6,
      OP_VS_MUL = 4'd7,
      OP_VS_DIV = 4'd8,
      OP_SV_DIV = 4'd9,
      OP_EQ     = 4'd10,
      OP_NE     = 4'd11,
      OP_DOT    = 4'd12,
      OP_MAG    = 4'd13,
      OP_NORM   = 4'd14,
      OP_DIST   = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0]        kind;
      logic signed [31:0] u_x;
      logic signed [31:0] u_y;
      logic signed [31:0] u_z;
      logic signed [31:0] u_w;
      logic signed [31:0] v_x;
      logic signed [31:0] v_y;
      logic signed [31:0] v_z;
      logic signed [31:0] v_w;
      logic signed [31:0] scalar_a;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic signed [31:0] res_z;
      logic signed [31:0] res_w;
      logic signed [31:0] res_scalar;
      logic              compare_true;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic           ovf;
      logic [Q_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic [Q_W-1:0]    res;
      logic              sat;
      logic [PROD_W-1:0] term;
      logic [PROD_W-2:0] sq;
      logic [Q_W-1:0]    num;
      logic [Q_W-1:0]    den;
   } lane_out_type;

   typedef struct packed {
      logic [Q_W-1:0] res;
      logic           sat;
      logic           dz;
   } div_out_type;

   typedef struct packed {
      op_type                         kind;
      logic                           cmp;
      logic                           u_zero;
      logic [Q_W-1:0]                 scal;
      logic                           scal_sat;
      logic [LANE_COUNT-1:0][Q_W-1:0] lane_res;
      logic [LANE_COUNT-1:0]          lane_sat;
      logic [LANE_COUNT-1:0][Q_W-1:0] num;
      logic [LANE_COUNT-1:0][Q_W-1:0] den;
   } side_type;

   function automatic sat_type sat_q(input logic signed [SUM_W-1:0] x);
      sat_type r;
      if (x > Q_MAX) begin
         r.ovf = 1'b1;
         r.val = QMAX32;
      end else if (x < Q_MIN) begin
         r.ovf = 1'b1;
         r.val = QMIN32;
      end else begin
         r.ovf = 1'b0;
         r.val = x[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/vector4_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// vector4_arithmetic_unit_core
// Four-lane Q-format vector ALU: lane adders and multipliers, a shared
// pipelined square root, four pipelined dividers and a merging output stage.
// Every opcode passes the full pipeline from the accepting edge to rsp_valid.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 34-stage square root feeding the 33-stage dividers.
// Reset clears the valid pipeline only; requests in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module vector4_arithmetic_unit_core
   import v4au_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int ROOT_TAP = SQRT_STAGES;
   localparam int DIV_TAP  = ROOT_TAP + 1 + DIV_STAGES;
   localparam int LATENCY  = DIV_TAP + 4;

   logic                    accept;
   logic signed [31:0]      u_lane [LANE_COUNT];
   logic signed [31:0]      v_lane [LANE_COUNT];
   lane_out_type            lane_out [LANE_COUNT];

   op_type                  kind_s1_ff, kind_s2_ff;
   logic                    eq_s1_ff, eq_s2_ff;
   logic                    uz_s1_ff, uz_s2_ff;
   logic                    vld_s1_ff, vld_s2_ff;
   logic [DIV_TAP:0]        side_vld_ff;

   logic signed [SUM_W-1:0] dot_sum;
   logic [SUM_W-1:0]        rad_sum;
   sat_type                 dot_sat;
   side_type                side_in;
   side_type                side_root;
   side_type                side_ff [0:DIV_TAP];
   logic [SUM_W-1:0]        rad_ff;
   logic [ROOT_W-1:0]       root;

   logic [DEN_W-1:0]        den_sel [LANE_COUNT];
   div_out_type             div_q [LANE_COUNT];

   side_type                fin;
   logic                    div_op;
   logic                    any_sat, any_dz;
   rsp_type                 rsp_in, rsp_ff;
   logic                    rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign u_lane[0] = req_data.u_x;
   assign u_lane[1] = req_data.u_y;
   assign u_lane[2] = req_data.u_z;
   assign u_lane[3] = req_data.u_w;
   assign v_lane[0] = req_data.v_x;
   assign v_lane[1] = req_data.v_y;
   assign v_lane[2] = req_data.v_z;
   assign v_lane[3] = req_data.v_w;

   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      v4au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_i (
         .clock    (clock),
         .kind     (op_type'(req_data.kind)),
         .u        (u_lane[i]),
         .v        (v_lane[i]),
         .a        (req_data.scalar_a),
         .lane_out (lane_out[i])
      );
   end

   always_ff @(posedge clock) begin
      kind_s1_ff <= op_type'(req_data.kind);
      eq_s1_ff   <= ({req_data.u_x, req_data.u_y, req_data.u_z, req_data.u_w} ==
                     {req_data.v_x, req_data.v_y, req_data.v_z, req_data.v_w});
      uz_s1_ff   <= ({req_data.u_x, req_data.u_y, req_data.u_z, req_data.u_w} == '0);
      kind_s2_ff <= kind_s1_ff;
      eq_s2_ff   <= eq_s1_ff;
      uz_s2_ff   <= uz_s1_ff;
   end

   always_comb begin
      dot_sum = '0;
      rad_sum = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         dot_sum = dot_sum + SUM_W'(signed'(lane_out[i].term));
         rad_sum = rad_sum + SUM_W'(lane_out[i].sq);
      end
      dot_sat = sat_q(dot_sum);

      side_in.kind     = kind_s2_ff;
      side_in.u_zero   = uz_s2_ff;
      side_in.cmp      = (kind_s2_ff == OP_EQ) ? eq_s2_ff :
                         (kind_s2_ff == OP_NE) ? !eq_s2_ff : 1'b0;
      side_in.scal     = (kind_s2_ff == OP_DOT) ? dot_sat.val : '0;
      side_in.scal_sat = (kind_s2_ff == OP_DOT) && dot_sat.ovf;
      for (int i = 0; i < LANE_COUNT; i++) begin
         side_in.lane_res[i] = lane_out[i].res;
         side_in.lane_sat[i] = lane_out[i].sat;
         side_in.num[i]      = lane_out[i].num;
         side_in.den[i]      = lane_out[i].den;
      end
   end

   v4au_sqrt u_sqrt (
      .clock (clock),
      .rad   (rad_ff),
      .root  (root)
   );

   always_comb begin
      side_root = side_ff[ROOT_TAP];
      if (side_ff[ROOT_TAP].kind == OP_MAG || side_ff[ROOT_TAP].kind == OP_DIST) begin
         if (root > ROOT_W'(QMAX32)) begin
            side_root.scal     = QMAX32;
            side_root.scal_sat = 1'b1;
         end else begin
            side_root.scal     = root[Q_W-1:0];
            side_root.scal_sat = 1'b0;
         end
      end
      for (int i = 0; i < LANE_COUNT; i++) begin
         if (side_ff[ROOT_TAP].kind == OP_NORM) begin
            den_sel[i] = {1'b0, root[Q_W:0]};
         end else begin
            den_sel[i] = {{(DEN_W-Q_W){side_ff[ROOT_TAP].den[i][Q_W-1]}},
                          side_ff[ROOT_TAP].den[i]};
         end
      end
   end

   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_div
      v4au_div #(.FRAC_BITS(FRAC_BITS)) u_div_i (
         .clock (clock),
         .num   (side_ff[ROOT_TAP].num[i]),
         .den   (den_sel[i]),
         .q     (div_q[i])
      );
   end

   always_ff @(posedge clock) begin
      rad_ff     <= rad_sum;
      side_ff[0] <= side_in;
      for (int k = 1; k <= DIV_TAP; k++) begin
         if (k == ROOT_TAP + 1) begin
            side_ff[k] <= side_root;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      logic [LANE_COUNT-1:0][Q_W-1:0] res;
      fin     = side_ff[DIV_TAP];
      div_op  = (fin.kind == OP_VV_DIV) || (fin.kind == OP_VS_DIV) ||
                (fin.kind == OP_SV_DIV) || (fin.kind == OP_NORM);
      any_sat = fin.scal_sat;
      any_dz  = 1'b0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         if (div_op) begin
            res[i]  = div_q[i].res;
            any_sat = any_sat | div_q[i].sat;
            any_dz  = any_dz | div_q[i].dz;
         end else begin
            res[i]  = fin.lane_res[i];
            any_sat = any_sat | fin.lane_sat[i];
         end
      end
      if (fin.kind == OP_NORM && fin.u_zero) begin
         res    = '0;
         any_dz = 1'b1;
      end
      rsp_in.res_x        = res[0];
      rsp_in.res_y        = res[1];
      rsp_in.res_z        = res[2];
      rsp_in.res_w        = res[3];
      rsp_in.res_scalar   = fin.scal;
      rsp_in.compare_true = fin.cmp;
      rsp_in.status       = any_dz ? ST_DZ : (any_sat ? ST_SAT : ST_OK);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff    <= 1'b0;
         vld_s2_ff    <= 1'b0;
         side_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_s1_ff    <= accept;
         vld_s2_ff    <= vld_s1_ff;
         side_vld_ff  <= {side_vld_ff[DIV_TAP-1:0], vld_s2_ff};
         rsp_valid_ff <= side_vld_ff[DIV_TAP];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without matching request");

   a_cmp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_true |-> rsp_data.status == ST_OK)
      else $error("compare result with nonzero status");

   a_scalar_vec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.res_scalar != 0 |->
         rsp_data.res_x == 0 && rsp_data.res_y == 0 &&
         rsp_data.res_z == 0 && rsp_data.res_w == 0)
      else $error("scalar result with nonzero vector");

endmodule

`default_nettype wire

@@ hdl/v4au_lane.sv @@
// ----------------------------------------------------------------------------
// v4au_lane
// One element lane: add/subtract with saturation, one multiplier for products
// and squares, and selection of the divide operands.
// ----------------------------------------------------------------------------
`default_nettype none

module v4au_lane
   import v4au_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  wire logic               clock,
   input  wire op_type             kind,
   input  wire logic signed [31:0] u,
   input  wire logic signed [31:0] v,
   input  wire logic signed [31:0] a,
   output lane_out_type            lane_out
);

   logic signed [32:0]        ue, ve, ae;
   logic signed [32:0]        add_in;
   logic signed [32:0]        ma, mb;
   logic [Q_W-1:0]            num_in, den_in;
   logic signed [PROD_W-1:0]  prod_in;
   sat_type                   as_in;

   op_type                    kind_ff;
   sat_type                   as_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [Q_W-1:0]            num_ff, den_ff;

   logic signed [PROD_W-1:0]  term;
   sat_type                   mul_sat;
   lane_out_type              out_in, out_ff;

   assign ue = {u[31], u};
   assign ve = {v[31], v};
   assign ae = {a[31], a};

   always_comb begin
      add_in = '0;
      ma     = '0;
      mb     = '0;
      num_in = '0;
      den_in = '0;
      unique case (kind) inside
         OP_VV_ADD: add_in = ue + ve;
         OP_VV_SUB: add_in = ue - ve;
         OP_VS_ADD: add_in = ue + ae;
         OP_VS_SUB: add_in = ue - ae;
         OP_SV_SUB: add_in = ae - ue;
         OP_VV_MUL, OP_DOT: begin
            ma = ue;
            mb = ve;
         end
         OP_VS_MUL: begin
            ma = ue;
            mb = ae;
         end
         OP_MAG: begin
            ma = ue;
            mb = ue;
         end
         OP_NORM: begin
            ma     = ue;
            mb     = ue;
            num_in = u;
         end
         OP_DIST: begin
            ma = ue - ve;
            mb = ue - ve;
         end
         OP_VV_DIV: begin
            num_in = u;
            den_in = v;
         end
         OP_VS_DIV: begin
            num_in = u;
            den_in = a;
         end
         OP_SV_DIV: begin
            num_in = a;
            den_in = u;
         end
         default: ;
      endcase
      as_in   = sat_q(SUM_W'(add_in));
      prod_in = ma * mb;
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind;
      as_ff   <= as_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   always_comb begin
      term    = prod_ff >>> FRAC_BITS;
      mul_sat = sat_q(SUM_W'(term));
      if (kind_ff == OP_VV_MUL || kind_ff == OP_VS_MUL) begin
         out_in.res = mul_sat.val;
         out_in.sat = mul_sat.ovf;
      end else begin
         out_in.res = as_ff.val;
         out_in.sat = as_ff.ovf;
      end
      out_in.term = term;
      out_in.sq   = prod_ff[PROD_W-2:0];
      out_in.num  = num_ff;
      out_in.den  = den_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign lane_out = out_ff;

endmodule

`default_nettype wire

@@ hdl/v4au_sqrt.sv @@
// ----------------------------------------------------------------------------
// v4au_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v4au_sqrt
   import v4au_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [SUM_W-1:0]  rad,
   output logic [ROOT_W-1:0]      root
);

   typedef struct packed {
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  rest;
   } sq_stage_type;

   function automatic sq_stage_type sq_step(input sq_stage_type s);
      sq_stage_type r;
      logic [ROOT_W+3:0] t;
      logic [ROOT_W+3:0] trial;
      t      = {s.rem, s.rest[SUM_W-1 -: 2]};
      trial  = {2'b00, s.root, 2'b01};
      r.rest = {s.rest[SUM_W-3:0], 2'b00};
      if (t >= trial) begin
         r.rem  = (ROOT_W+2)'(t - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = t[ROOT_W+1:0];
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   sq_stage_type sq_ff [0:SQRT_STAGES-1];
   sq_stage_type sq_in [0:SQRT_STAGES-1];
   sq_stage_type seed;

   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.rest = rad;
      sq_in[0]  = sq_step(seed);
      for (int k = 1; k < SQRT_STAGES; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         sq_ff[k] <= sq_in[k];
      end
   end

   assign root = sq_ff[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

@@ hdl/v4au_div.sv @@
// ----------------------------------------------------------------------------
// v4au_div
// Pipelined signed fixed-point divider, one quotient bit per stage, with
// saturation and divide-by-zero handling.
// ----------------------------------------------------------------------------
`default_nettype none

module v4au_div
   import v4au_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic [Q_W-1:0]     num,
   input  wire logic [DEN_W-1:0]   den,
   output div_out_type             q
);

   localparam int NUM_W = Q_W + FRAC_BITS;

   typedef struct packed {
      logic [Q_W:0]   rem;
      logic [Q_W-1:0] lo;
      logic [Q_W-1:0] quo;
      logic [Q_W:0]   dmag;
      logic           neg;
      logic           nneg;
      logic           dz;
      logic           ovf;
   } dv_stage_type;

   function automatic dv_stage_type dv_step(input dv_stage_type s);
      dv_stage_type r;
      logic [Q_W+1:0] t;
      r   = s;
      t   = {s.rem, s.lo[Q_W-1]};
      r.lo = {s.lo[Q_W-2:0], 1'b0};
      if (t >= {1'b0, s.dmag}) begin
         r.rem = (Q_W+1)'(t - {1'b0, s.dmag});
         r.quo = {s.quo[Q_W-2:0], 1'b1};
      end else begin
         r.rem = t[Q_W:0];
         r.quo = {s.quo[Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [Q_W-1:0]   nabs;
   logic [DEN_W-1:0] dabs;
   logic [NUM_W-1:0] nmag;
   dv_stage_type     prep;
   dv_stage_type     dv_ff [0:DIV_STAGES];
   dv_stage_type     dv_in [1:DIV_STAGES];
   dv_stage_type     last;

   always_comb begin
      nabs      = num[Q_W-1] ? (Q_W)'(-num) : num;
      dabs      = den[DEN_W-1] ? (DEN_W)'(-den) : den;
      nmag      = {nabs, {FRAC_BITS{1'b0}}};
      prep.rem  = (Q_W+1)'(nmag[NUM_W-1:Q_W]);
      prep.lo   = nmag[Q_W-1:0];
      prep.quo  = '0;
      prep.dmag = dabs[Q_W:0];
      prep.neg  = num[Q_W-1] ^ den[DEN_W-1];
      prep.nneg = num[Q_W-1];
      prep.dz   = (den == '0);
      prep.ovf  = (65'(nmag) >= {dabs[Q_W:0], {Q_W{1'b0}}});
      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_in[k] = dv_step(dv_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      dv_ff[0] <= prep;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_ff[k] <= dv_in[k];
      end
   end

   assign last = dv_ff[DIV_STAGES];

   always_comb begin
      q.sat = 1'b0;
      q.dz  = 1'b0;
      if (last.dz) begin
         q.dz  = 1'b1;
         q.res = last.nneg ? QMIN32 : QMAX32;
      end else if (last.ovf) begin
         q.sat = 1'b1;
         q.res = last.neg ? QMIN32 : QMAX32;
      end else if (!last.neg) begin
         if (last.quo[Q_W-1]) begin
            q.sat = 1'b1;
            q.res = QMAX32;
         end else begin
            q.res = last.quo;
         end
      end else begin
         if (last.quo > QMIN32) begin
            q.sat = 1'b1;
            q.res = QMIN32;
         end else begin
            q.res = (Q_W)'(-last.quo);
         end
      end
   end

endmodule

`default_nettype wire

@@ test/vector4_arithmetic_unit_core_test.sv @@
// ----------------------------------------------------------------------------
// vector4_arithmetic_unit_core_test
// Drives directed and random vector requests through the four-lane ALU with
// random gaps, predicts every response in a behavioral model of the Q16.16
// arithmetic and compares each response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector4_arithmetic_unit_core_test;
   import v4au_pkg::*;

   localparam int FRAC = 16;
   localparam int RANDOM_REQUESTS = 1100;
   localparam longint CYCLE_LIMIT = 200000;
   localparam longint S_MAX = 64'sd2147483647;
   localparam longint S_MIN = -64'sd2147483648;

   class alu_scoreboard;
      rsp_type pending[$];
      int mismatches;

      function automatic longint clamp(input longint x, inout bit sat);
         if (x > S_MAX) begin
            sat = 1;
            return S_MAX;
         end
         if (x < S_MIN) begin
            sat = 1;
            return S_MIN;
         end
         return x;
      endfunction

      function automatic longint fix_mul(input longint a, input longint b, inout bit sat);
         return clamp((a * b) >>> FRAC, sat);
      endfunction

      function automatic longint fix_div(input longint a, input longint b,
                                         inout bit sat, inout bit dz);
         if (b == 0) begin
            dz = 1;
            return (a < 0) ? S_MIN : S_MAX;
         end
         return clamp((a * (64'sd1 <<< FRAC)) / b, sat);
      endfunction

      // floor sqrt of a 68-bit sum of squares
      function automatic logic [67:0] root_of(input logic [67:0] n);
         logic [67:0] r, b;
         r = 0;
         b = 68'd1 << 66;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic logic [67:0] length_of(input longint d[4]);
         logic [67:0] sum;
         logic [33:0] m;
         sum = 0;
         for (int i = 0; i < 4; i++) begin
            m = (d[i] < 0) ? -d[i] : d[i];
            sum = sum + 68'(m) * 68'(m);
         end
         return root_of(sum);
      endfunction

      function void note_request(input req_type q);
         longint u[4], v[4], r[4], d[4], a, acc;
         logic [67:0] m;
         bit sat, dz, eq;
         op_type k;
         rsp_type e;
         u = '{longint'(q.u_x), longint'(q.u_y), longint'(q.u_z), longint'(q.u_w)};
         v = '{longint'(q.v_x), longint'(q.v_y), longint'(q.v_z), longint'(q.v_w)};
         a = longint'(q.scalar_a);
         r = '{0, 0, 0, 0};
         sat = 0;
         dz = 0;
         e = '0;
         k = op_type'(q.kind);
         case (k)
            OP_EQ, OP_NE: begin
               eq = 1;
               for (int i = 0; i < 4; i++) if (u[i] != v[i]) eq = 0;
               e.compare_true = (k == OP_EQ) ? eq : !eq;
            end
            OP_DOT: begin
               acc = 0;
               for (int i = 0; i < 4; i++) acc += (u[i] * v[i]) >>> FRAC;
               e.res_scalar = 32'(clamp(acc, sat));
            end
            OP_MAG, OP_DIST: begin
               for (int i = 0; i < 4; i++) d[i] = (k == OP_MAG) ? u[i] : u[i] - v[i];
               m = length_of(d);
               if (m > 68'(S_MAX)) begin
                  sat = 1;
                  e.res_scalar = 32'(S_MAX);
               end else begin
                  e.res_scalar = 32'(m);
               end
            end
            OP_NORM: begin
               m = length_of(u);
               if (m == 0) dz = 1;
               else for (int i = 0; i < 4; i++)
                  r[i] = clamp((u[i] * (64'sd1 <<< FRAC)) / longint'(m), sat);
            end
            default:
               for (int i = 0; i < 4; i++) begin
                  case (k)
                     OP_VV_ADD: r[i] = clamp(u[i] + v[i], sat);
                     OP_VV_SUB: r[i] = clamp(u[i] - v[i], sat);
                     OP_VV_MUL: r[i] = fix_mul(u[i], v[i], sat);
                     OP_VV_DIV: r[i] = fix_div(u[i], v[i], sat, dz);
                     OP_VS_ADD: r[i] = clamp(u[i] + a, sat);
                     OP_VS_SUB: r[i] = clamp(u[i] - a, sat);
                     OP_SV_SUB: r[i] = clamp(a - u[i], sat);
                     OP_VS_MUL: r[i] = fix_mul(u[i], a, sat);
                     OP_VS_DIV: r[i] = fix_div(u[i], a, sat, dz);
                     default:   r[i] = fix_div(a, u[i], sat, dz);
                  endcase
               end
         endcase
         e.res_x = 32'(r[0]);
         e.res_y = 32'(r[1]);
         e.res_z = 32'(r[2]);
         e.res_w = 32'(r[3]);
         e.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
         pending.push_back(e);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.res_x !== e.res_x || got.res_y !== e.res_y || got.res_z !== e.res_z ||
             got.res_w !== e.res_w || got.res_scalar !== e.res_scalar ||
             got.compare_true !== e.compare_true || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h %h %h %h %h %b %0d, got %h %h %h %h %h %b %0d",
                        e.res_x, e.res_y, e.res_z, e.res_w, e.res_scalar,
                        e.compare_true, e.status, got.res_x, got.res_y, got.res_z,
                        got.res_w, got.res_scalar, got.compare_true, got.status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   longint cycles = 0;
   alu_scoreboard board;

   vector4_arithmetic_unit_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_response(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
         4: return 32'($signed($urandom_range(0, 131072)) - 65536);
         5: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input req_type q, input int gap);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_data <= q;
      do @(posedge clock); while (busy);
      board.note_request(q);
      @(negedge clock);
   endtask

   task automatic send_vector(input op_type k, input logic [31:0] c, input logic [31:0] s,
                              input logic [31:0] a);
      req_type q;
      q.kind = k;
      q.u_x = c; q.u_y = c; q.u_z = c; q.u_w = c;
      q.v_x = s; q.v_y = s; q.v_z = s; q.v_w = s;
      q.scalar_a = a;
      send_request(q, 0);
   endtask

   initial begin
      req_type q;
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int k = 0; k < 16; k++)
         send_vector(op_type'(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_vector(OP_VV_DIV, 32'h8000_0000, 32'h0, 32'h0);
      send_vector(OP_VS_DIV, 32'h0, 32'h0, 32'h0);
      send_vector(OP_SV_DIV, 32'h0, 32'h0, 32'hFFFF_0000);
      send_vector(OP_NORM, 32'h0, 32'h0, 32'h0);
      send_vector(OP_MAG, 32'h8000_0000, 32'h0, 32'h0);
      send_vector(OP_EQ, 32'h1234_5678, 32'h1234_5678, 32'h0);
      send_vector(OP_NE, 32'h1234_5678, 32'h1234_5678, 32'h0);
      send_vector(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h0);
      send_vector(OP_NORM, 32'h8000_0000, 32'h0, 32'h0);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         q.kind = 4'($urandom_range(0, 15));
         q.u_x = pick_value(); q.u_y = pick_value();
         q.u_z = pick_value(); q.u_w = pick_value();
         q.v_x = pick_value(); q.v_y = pick_value();
         q.v_z = pick_value(); q.v_w = pick_value();
         q.scalar_a = pick_value();
         if (q.kind == OP_EQ && $urandom_range(0, 1))
            {q.v_x, q.v_y, q.v_z, q.v_w} = {q.u_x, q.u_y, q.u_z, q.u_w};
         send_request(q, (n % 200 < 50) ? 0 : $urandom_range(0, 6));
      end
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (board.mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
